@@ rtl/core/i2c_button_led_bridge_master_defines.svh @@
// Assertion helpers shared by the bridge RTL.
`ifndef I2C_BUTTON_LED_BRIDGE_MASTER_DEFINES_SVH
`define I2C_BUTTON_LED_BRIDGE_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IBL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IBL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ibl_pkg.sv @@
package ibl_pkg;

   // Sequencer state: waiting for a poll, or emitting its pin events.
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctl_state_type;

   // Bus mode kept between polls.
   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_SHIFT = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_READ  = 2'd3
   } bus_mode_type;

   // One pin event as handed from the sequencer to the output stage.
   typedef struct packed {
      logic scl;
      logic sda;
      logic restart;
      logic last;
   } ev_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_READ_ADDR  = 2'd0;
   localparam logic [1:0] REG_WRITE_ADDR = 2'd1;

   // Register reset values.
   localparam logic [7:0] READ_ADDR_RESET  = 8'h41;
   localparam logic [7:0] WRITE_ADDR_RESET = 8'h40;

   // Bit counter value of the acknowledge clock after eight data bits.
   localparam logic [3:0] ACK_BIT  = 4'd8;
   localparam logic [3:0] LAST_BIT = 4'd7;

   // Phases of one bit slot: set data, clock high, clock low.
   localparam logic [1:0] PH_DATA = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;
   localparam logic [1:0] PH_END  = 2'd3;

endpackage

@@ rtl/core/ibl_out_stage.sv @@
module ibl_out_stage (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ibl_pkg::ev_type ev,
   output logic           ready_o,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,   // [0] scl_level, [1] sda_level, [7:2] zero
   output logic           rsp_tuser,   // [0] restart_timer
   output logic           rsp_tlast    // last_event
);

   logic           valid_ff;
   logic           valid_in;
   ibl_pkg::ev_type ev_ff;

   // A new event may enter when the stage is empty or is being drained.
   assign ready_o = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded only on a push.
   always_ff @(posedge clock) begin
      if (push) begin
         ev_ff <= ev;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, ev_ff.sda, ev_ff.scl};
   assign rsp_tuser  = ev_ff.restart;
   assign rsp_tlast  = ev_ff.last;

endmodule

@@ rtl/core/i2c_button_led_bridge_master.sv @@
// Each accepted poll emits its pin events one per cycle while the output stage can take
// them: 4 for start or stop, 27 for a byte shifted out, 19 for a byte read; a poll in wait
// mode without timer emits none. The poll moves the sequencer into its run state, and each
// event is then registered in the output stage; the single event sequencer walks bit and phase.
// Reset (synchronous, active high) returns the bus to idle with both pins released,
// the addresses to 0x41 and 0x40, and the next transaction to the LED write.
`include "i2c_button_led_bridge_master_defines.svh"

module i2c_button_led_bridge_master (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] sda_sample_byte
   input  logic       req_tuser,   // [0] timer_expired
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] scl_level, [1] sda_level, [7:2] zero
   output logic       rsp_tuser,   // [0] restart_timer
   output logic       rsp_tlast,   // last_event
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   ibl_pkg::ctl_state_type state_ff, state_in;
   ibl_pkg::bus_mode_type  mode_ff, mode_in;
   logic [7:0] read_addr_ff;
   logic [7:0] write_addr_ff;
   logic       addr_done_ff, addr_done_in;
   logic       write_pend_ff, write_pend_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] button_ff, button_in;
   logic       scl_pin_ff, scl_pin_in;
   logic       sda_pin_ff, sda_pin_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [1:0] phase_ff, phase_in;
   logic       out_ready;
   logic       push;
   ibl_pkg::ev_type ev;
   logic       byte_run;
   logic       start_slot;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         read_addr_ff  <= ibl_pkg::READ_ADDR_RESET;
         write_addr_ff <= ibl_pkg::WRITE_ADDR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ibl_pkg::REG_READ_ADDR:  read_addr_ff  <= csr_wdata;
            ibl_pkg::REG_WRITE_ADDR: write_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ibl_pkg::ST_IDLE);

   // Event sequencer: one pin event per cycle with out_ready high; data bits leave shift_ff MSB first.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      addr_done_in  = addr_done_ff;
      write_pend_in = write_pend_ff;
      shift_in      = shift_ff;
      button_in     = button_ff;
      scl_pin_in    = scl_pin_ff;
      sda_pin_in    = sda_pin_ff;
      bit_cnt_in    = bit_cnt_ff;
      phase_in      = phase_ff;
      push          = 1'b0;
      ev            = '0;

      case (state_ff)
         ibl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (mode_ff != ibl_pkg::MODE_WAIT || req_tuser) begin
                  state_in   = ibl_pkg::ST_RUN;
                  bit_cnt_in = 4'd0;
                  phase_in   = (mode_ff == ibl_pkg::MODE_READ) ? ibl_pkg::PH_HIGH
                                                                : ibl_pkg::PH_DATA;
               end
               // Only the low nibble of the read byte survives into the LED data.
               if (mode_ff == ibl_pkg::MODE_READ) begin
                  button_in = req_tdata[3:0];
               end
            end
         end

         ibl_pkg::ST_RUN: begin
            if (out_ready) begin
               push = 1'b1;
               case (mode_ff)
                  ibl_pkg::MODE_WAIT, ibl_pkg::MODE_STOP: begin
                     // Start: SDA high, SCL high, SDA low, SCL low.
                     // Stop:  SDA low,  SCL high, SDA high, SCL low.
                     case (phase_ff)
                        ibl_pkg::PH_DATA: begin
                           sda_pin_in = (mode_ff == ibl_pkg::MODE_WAIT);
                           ev.restart = (mode_ff == ibl_pkg::MODE_WAIT);
                        end
                        ibl_pkg::PH_HIGH: scl_pin_in = 1'b1;
                        ibl_pkg::PH_LOW:  sda_pin_in = (mode_ff == ibl_pkg::MODE_STOP);
                        default:          scl_pin_in = 1'b0;
                     endcase
                     phase_in = phase_ff + 2'd1;
                     if (phase_ff == ibl_pkg::PH_END) begin
                        ev.last  = 1'b1;
                        state_in = ibl_pkg::ST_IDLE;
                        if (mode_ff == ibl_pkg::MODE_WAIT) begin
                           mode_in      = ibl_pkg::MODE_SHIFT;
                           addr_done_in = 1'b0;
                           shift_in     = write_pend_ff ? write_addr_ff : read_addr_ff;
                        end else begin
                           mode_in = ibl_pkg::MODE_WAIT;
                        end
                     end
                  end

                  default: begin
                     // Byte shift out or read, then the acknowledge clock.
                     case (phase_ff)
                        ibl_pkg::PH_DATA: begin
                           sda_pin_in = (bit_cnt_ff == ibl_pkg::ACK_BIT) ||
                                        (mode_ff == ibl_pkg::MODE_READ) || shift_ff[7];
                           phase_in   = ibl_pkg::PH_HIGH;
                        end
                        ibl_pkg::PH_HIGH: begin
                           scl_pin_in = 1'b1;
                           phase_in   = ibl_pkg::PH_LOW;
                        end
                        default: begin
                           scl_pin_in = 1'b0;
                           bit_cnt_in = bit_cnt_ff + 4'd1;
                           phase_in   = (mode_ff == ibl_pkg::MODE_READ &&
                                         bit_cnt_ff != ibl_pkg::LAST_BIT) ?
                                        ibl_pkg::PH_HIGH : ibl_pkg::PH_DATA;
                           if (mode_ff == ibl_pkg::MODE_SHIFT &&
                               bit_cnt_ff != ibl_pkg::ACK_BIT) begin
                              shift_in = {shift_ff[6:0], 1'b0};
                           end
                        end
                     endcase

                     if (bit_cnt_ff == ibl_pkg::ACK_BIT && phase_ff == ibl_pkg::PH_LOW) begin
                        // The byte is done, so the bit counter parks at zero.
                        ev.last    = 1'b1;
                        state_in   = ibl_pkg::ST_IDLE;
                        bit_cnt_in = 4'd0;
                        if (mode_ff == ibl_pkg::MODE_READ) begin
                           write_pend_in = 1'b1;
                           mode_in       = ibl_pkg::MODE_STOP;
                        end else if (!addr_done_ff && !write_pend_ff) begin
                           addr_done_in = 1'b1;
                           mode_in      = ibl_pkg::MODE_READ;
                        end else if (!addr_done_ff) begin
                           // Address of the LED write sent: the data byte follows.
                           addr_done_in  = 1'b1;
                           write_pend_in = 1'b0;
                           shift_in      = {~button_ff, 4'b0};
                           mode_in       = ibl_pkg::MODE_SHIFT;
                        end else begin
                           mode_in = ibl_pkg::MODE_STOP;
                        end
                     end
                  end
               endcase
               ev.scl = scl_pin_in;
               ev.sda = sda_pin_in;
            end
         end

         default: state_in = ibl_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibl_pkg::ST_IDLE;
         mode_ff       <= ibl_pkg::MODE_WAIT;
         addr_done_ff  <= 1'b0;
         write_pend_ff <= 1'b1;
         shift_ff      <= 8'h00;
         button_ff     <= 4'h0;
         scl_pin_ff    <= 1'b1;
         sda_pin_ff    <= 1'b1;
         bit_cnt_ff    <= 4'd0;
         phase_ff      <= ibl_pkg::PH_DATA;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         addr_done_ff  <= addr_done_in;
         write_pend_ff <= write_pend_in;
         shift_ff      <= shift_in;
         button_ff     <= button_in;
         scl_pin_ff    <= scl_pin_in;
         sda_pin_ff    <= sda_pin_in;
         bit_cnt_ff    <= bit_cnt_in;
         phase_ff      <= phase_in;
      end
   end

   // Output register that parts the sequencer from the result channel.
   ibl_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .ev         (ev),
      .ready_o    (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Conditions watched by the checks below.
   assign byte_run   = (state_ff == ibl_pkg::ST_RUN) &&
                       (mode_ff == ibl_pkg::MODE_SHIFT || mode_ff == ibl_pkg::MODE_READ);
   assign start_slot = (mode_ff == ibl_pkg::MODE_WAIT) && (phase_ff == ibl_pkg::PH_DATA);

   `IBL_ASSERT_NOW(a_bit_cnt_range, 1'b1, bit_cnt_ff <= ibl_pkg::ACK_BIT, "bit counter overrun")
   `IBL_ASSERT_NOW(a_phase_byte, byte_run, phase_ff != ibl_pkg::PH_END, "bad phase in byte mode")
   `IBL_ASSERT_NOW(a_restart_start, push && ev.restart, start_slot, "restart outside start")
   `IBL_ASSERT_NEXT(a_last_idle, push && ev.last, state_ff == ibl_pkg::ST_IDLE, "no idle after last")

endmodule
